/* hw/rtl/gpw_pkg.sv */
// Package for the GCC-PHAT bin weighting pipeline: a shared control type, constants and
// elaboration-time helpers (bit length, integer square root, exp2 factors).
// No dependencies.
package gpw_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int EXP_WIDTH        = 14;
	localparam logic signed [EXP_WIDTH-1:0] EXP_RESET = -14'sd2048;
	localparam int LOG_STEPS        = 16;
	localparam int EXP_STEPS        = 16;
	localparam int MAN_W            = 31;   // Q1.30 mantissa
	localparam int OUT_W            = 32;

	// valid bit and frame mark that travel with each item
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

	// position of the leading one plus one, zero for zero
	function automatic logic [6:0] bit_len(input logic [63:0] v);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = 7'(i + 1);
		end
		return n;
	endfunction

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] b;
		rem = v;
		res = '0;
		b   = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// 2^(2^-(idx+1)) in Q1.30, by repeated integer square roots
	function automatic logic [31:0] exp_factor(input int idx);
		logic [63:0] c;
		c = 64'h8000_0000;
		for (int i = 0; i <= idx; i++) begin
			c = isqrt(c << 30);
		end
		return c[31:0];
	endfunction

endpackage

/* hw/rtl/gcc_phat_bin_weighting.sv */
// GCC-PHAT bin weighting, top level: exponent register, handshake and the
// pipeline of gpw_xspec, gpw_log2, gpw_exp2 and gpw_scale. Uses gpw_pkg.
//
// Takes one bin of each of two spectra per item and returns X*conj(Y) scaled
// by |X*conj(Y)|^(2e) in signed Q16.16, saturated, with e the exponent register
// (signed Q2.12, reset -0.5 for plain PHAT). One item enters every cycle
// while the output is not stalled and passes 7 front-end, 18 log2, 18 exp2
// and 7 scaling stages; the 16 squarings of the log2 and the 16 factor
// multiplies of the exp2 set that depth, one multiply per stage. The whole
// pipeline advances as one when the output register is empty or being taken,
// so a stall on the master side holds every stage and drops nothing. A zero
// cross-spectrum gives zero without saturation. Write the exponent only while
// no item is in flight.
module gcc_phat_bin_weighting #(
	parameter int SAMPLE_WIDTH = gpw_pkg::SAMPLE_WIDTH_DEF,
	localparam int IN_W = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// exponent write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gpw_pkg::EXP_WIDTH-1:0]        cfg_data,
	// bins in
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// x_real, x_imag, y_real, y_imag, zero fill
	input  logic [IN_W-1:0]                      s_axis_tdata,
	input  logic                                 s_axis_tlast,    // last_bin
	// weighted bins out
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// weighted_real, weighted_imag
	output logic [2*gpw_pkg::OUT_W-1:0]          m_axis_tdata,
	output logic                                 m_axis_tuser,    // saturated
	output logic                                 m_axis_tlast     // last_bin_out
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CW  = 2 * SW + 1;
	localparam int SHW = $clog2(CW + 1);
	localparam int IPW = $clog2(4 * SW) + 1;
	localparam int LQW = IPW + 16;
	localparam int KW  = IPW + 3;

	logic signed [gpw_pkg::EXP_WIDTH-1:0] weight_exponent_q;
	logic          en;
	gpw_pkg::ctl_t in_ctl, xs_ctl, lg_ctl, ex_ctl, sc_ctl;

	logic signed [CW-1:0]  xs_cr, xs_ci, lg_cr, lg_ci, ex_cr, ex_ci;
	logic [62:0]           xs_m2;
	logic [SHW-1:0]        xs_sh;
	logic signed [LQW-1:0] lg_lq;
	logic signed [KW-1:0]  ex_k;
	logic [gpw_pkg::MAN_W-1:0] ex_m;
	logic [gpw_pkg::OUT_W-1:0] wr, wi;
	logic                  sat;

	// exponent register: always ready; the user must see that it is written between frames, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_exponent_q <= gpw_pkg::EXP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			weight_exponent_q <= $signed(cfg_data);
		end
	end

	// advance every stage while the output register is free or being taken
	assign en            = !sc_ctl.valid || m_axis_tready;
	assign s_axis_tready = en;

	assign in_ctl.valid = s_axis_tvalid;
	assign in_ctl.last  = s_axis_tlast;

	gpw_xspec #(.SW(SW)) u_xspec (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (in_ctl),
		.x_real  ($signed(s_axis_tdata[SW-1:0])),
		.x_imag  ($signed(s_axis_tdata[2*SW-1:SW])),
		.y_real  ($signed(s_axis_tdata[3*SW-1:2*SW])),
		.y_imag  ($signed(s_axis_tdata[4*SW-1:3*SW])),
		.out_ctl (xs_ctl),
		.cr      (xs_cr),
		.ci      (xs_ci),
		.m2      (xs_m2),
		.sh      (xs_sh)
	);

	gpw_log2 #(.SW(SW)) u_log2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (xs_ctl),
		.cr_in   (xs_cr),
		.ci_in   (xs_ci),
		.m2      (xs_m2),
		.sh      (xs_sh),
		.out_ctl (lg_ctl),
		.cr_out  (lg_cr),
		.ci_out  (lg_ci),
		.lq      (lg_lq)
	);

	gpw_exp2 #(.SW(SW)) u_exp2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (lg_ctl),
		.cr_in   (lg_cr),
		.ci_in   (lg_ci),
		.lq      (lg_lq),
		.wexp    (weight_exponent_q),
		.out_ctl (ex_ctl),
		.cr_out  (ex_cr),
		.ci_out  (ex_ci),
		.k       (ex_k),
		.m       (ex_m)
	);

	gpw_scale #(.SW(SW)) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (ex_ctl),
		.cr      (ex_cr),
		.ci      (ex_ci),
		.k       (ex_k),
		.m       (ex_m),
		.out_ctl (sc_ctl),
		.wr      (wr),
		.wi      (wi),
		.sat     (sat)
	);

	assign m_axis_tvalid = sc_ctl.valid;
	assign m_axis_tdata  = {wi, wr};
	assign m_axis_tuser  = sat;
	assign m_axis_tlast  = sc_ctl.last;

	// a held output item must hold the input side too
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	// an exponent write lands in the register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> weight_exponent_q == $past($signed(cfg_data)))
		else $error("exponent write lost");

	// a clipped item is never zero in both parts
	a_sat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata != '0)
		else $error("saturation flagged on a zero item");

endmodule

/* hw/rtl/gpw_xspec.sv */
// Cross-spectrum front end: products, sums, magnitudes, range cut and
// squared magnitude over seven register stages. Uses gpw_pkg.
module gpw_xspec #(
	parameter int SW = gpw_pkg::SAMPLE_WIDTH_DEF,
	localparam int CW = 2 * SW + 1,
	localparam int SHW = $clog2(CW + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  gpw_pkg::ctl_t        in_ctl,
	input  logic signed [SW-1:0] x_real,
	input  logic signed [SW-1:0] x_imag,
	input  logic signed [SW-1:0] y_real,
	input  logic signed [SW-1:0] y_imag,
	output gpw_pkg::ctl_t        out_ctl,
	output logic signed [CW-1:0] cr,
	output logic signed [CW-1:0] ci,
	output logic [62:0]          m2,
	output logic [SHW-1:0]       sh
);

	gpw_pkg::ctl_t ctl_d [1:7];

	logic signed [2*SW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1;
	logic signed [CW-1:0]   cr_d [2:7];
	logic signed [CW-1:0]   ci_d [2:7];
	logic [CW-1:0]          ar_s3, ai_s3, ar_s4, ai_s4;
	logic [SHW-1:0]         sh_d [4:7];
	logic [30:0]            ar_s5, ai_s5;
	logic [61:0]            sq_r_s6, sq_i_s6;
	logic [62:0]            m2_s7;
	logic [6:0]             bl_s3;
	logic [SHW-1:0]         sh_n;

	always_comb begin
		bl_s3 = gpw_pkg::bit_len(64'(ar_s3 | ai_s3));
		sh_n  = (bl_s3 > 7'd31) ? SHW'(bl_s3 - 7'd31) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_d <= '{default: '0};
		end else if (en) begin
			ctl_d[1] <= in_ctl;
			for (int i = 2; i <= 7; i++) ctl_d[i] <= ctl_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s1 <= x_real * y_real;
			p_ii_s1 <= x_imag * y_imag;
			p_ir_s1 <= x_imag * y_real;
			p_ri_s1 <= x_real * y_imag;
			cr_d[2] <= CW'(p_rr_s1) + CW'(p_ii_s1);
			ci_d[2] <= CW'(p_ir_s1) - CW'(p_ri_s1);
			for (int i = 3; i <= 7; i++) begin
				cr_d[i] <= cr_d[i-1];
				ci_d[i] <= ci_d[i-1];
			end
			ar_s3   <= cr_d[2][CW-1] ? CW'(-cr_d[2]) : CW'(cr_d[2]);
			ai_s3   <= ci_d[2][CW-1] ? CW'(-ci_d[2]) : CW'(ci_d[2]);
			ar_s4   <= ar_s3;
			ai_s4   <= ai_s3;
			sh_d[4] <= sh_n;
			for (int i = 5; i <= 7; i++) sh_d[i] <= sh_d[i-1];
			ar_s5   <= 31'(ar_s4 >> sh_d[4]);
			ai_s5   <= 31'(ai_s4 >> sh_d[4]);
			sq_r_s6 <= ar_s5 * ar_s5;
			sq_i_s6 <= ai_s5 * ai_s5;
			m2_s7   <= 63'(sq_r_s6) + 63'(sq_i_s6);
		end
	end

	assign out_ctl = ctl_d[7];
	assign cr      = cr_d[7];
	assign ci      = ci_d[7];
	assign m2      = m2_s7;
	assign sh      = sh_d[7];

endmodule

/* hw/rtl/gpw_log2.sv */
// Fixed-length log2 of the squared magnitude: leading-one search, normalise,
// then one squaring per stage for sixteen fraction bits. Uses gpw_pkg.
module gpw_log2 #(
	parameter int SW = gpw_pkg::SAMPLE_WIDTH_DEF,
	localparam int CW = 2 * SW + 1,
	localparam int SHW = $clog2(CW + 1),
	localparam int IPW = $clog2(4 * SW) + 1,
	localparam int LQW = IPW + 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  gpw_pkg::ctl_t         in_ctl,
	input  logic signed [CW-1:0]  cr_in,
	input  logic signed [CW-1:0]  ci_in,
	input  logic [62:0]           m2,
	input  logic [SHW-1:0]        sh,
	output gpw_pkg::ctl_t         out_ctl,
	output logic signed [CW-1:0]  cr_out,
	output logic signed [CW-1:0]  ci_out,
	output logic signed [LQW-1:0] lq
);

	localparam int F = 2 * (SW - 1);
	localparam int D = gpw_pkg::LOG_STEPS + 2;

	gpw_pkg::ctl_t        ctl_d [1:D];
	logic signed [CW-1:0] cr_d [1:D];
	logic signed [CW-1:0] ci_d [1:D];
	logic [5:0]           p_s1;
	logic [62:0]          m2_s1;
	logic [SHW-1:0]       sh_s1;
	logic [30:0]          x_d [2:D];
	logic [15:0]          fr_d [2:D];
	logic [IPW-1:0]       ip_d [2:D];
	logic [30:0]          xn;
	logic [IPW-1:0]       ipn;

	always_comb begin
		if (p_s1 >= 6'd30) begin
			xn = 31'(m2_s1 >> (p_s1 - 6'd30));
		end else begin
			xn = 31'(m2_s1 << (6'd30 - p_s1));
		end
		ipn = IPW'(int'(p_s1) + 2 * int'(sh_s1) - 2 * F);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_d <= '{default: '0};
		end else if (en) begin
			ctl_d[1] <= in_ctl;
			for (int i = 2; i <= D; i++) ctl_d[i] <= ctl_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_d[1] <= cr_in;
			ci_d[1] <= ci_in;
			for (int i = 2; i <= D; i++) begin
				cr_d[i] <= cr_d[i-1];
				ci_d[i] <= ci_d[i-1];
			end
			p_s1    <= 6'(gpw_pkg::bit_len(64'(m2)) - 7'd1);
			m2_s1   <= m2;
			sh_s1   <= sh;
			x_d[2]  <= xn;
			fr_d[2] <= '0;
			ip_d[2] <= ipn;
		end
	end

	// one squaring per stage; an overflow past 2.0 yields a one bit
	for (genvar j = 0; j < gpw_pkg::LOG_STEPS; j++) begin : g_step
		logic [61:0] sq;
		logic [31:0] y;
		assign sq = x_d[j+2] * x_d[j+2];
		assign y  = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				x_d[j+3]  <= y[31] ? y[31:1] : y[30:0];
				fr_d[j+3] <= {fr_d[j+2][14:0], y[31]};
				ip_d[j+3] <= ip_d[j+2];
			end
		end
	end

	assign out_ctl = ctl_d[D];
	assign cr_out  = cr_d[D];
	assign ci_out  = ci_d[D];
	assign lq      = $signed({ip_d[D], fr_d[D]});

endmodule

/* hw/rtl/gpw_exp2.sv */
// Exponent multiply and fixed-length exp2: one factor of the step table per
// stage. Uses gpw_pkg for the table and the exponent width.
module gpw_exp2 #(
	parameter int SW = gpw_pkg::SAMPLE_WIDTH_DEF,
	localparam int CW = 2 * SW + 1,
	localparam int IPW = $clog2(4 * SW) + 1,
	localparam int LQW = IPW + 16,
	localparam int KW = IPW + 3
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  gpw_pkg::ctl_t                           in_ctl,
	input  logic signed [CW-1:0]                    cr_in,
	input  logic signed [CW-1:0]                    ci_in,
	input  logic signed [LQW-1:0]                   lq,
	input  logic signed [gpw_pkg::EXP_WIDTH-1:0]    wexp,
	output gpw_pkg::ctl_t                           out_ctl,
	output logic signed [CW-1:0]                    cr_out,
	output logic signed [CW-1:0]                    ci_out,
	output logic signed [KW-1:0]                    k,
	output logic [gpw_pkg::MAN_W-1:0]               m
);

	localparam int F  = 2 * (SW - 1);
	localparam int PW = gpw_pkg::EXP_WIDTH + LQW;
	localparam int TW = LQW + 3;
	localparam int D  = gpw_pkg::EXP_STEPS + 2;
	localparam logic signed [PW-1:0] RND    = PW'(2048);
	localparam logic signed [TW-1:0] TT_OFF = TW'((16 - F) * 65536);

	gpw_pkg::ctl_t        ctl_d [1:D];
	logic signed [CW-1:0] cr_d [1:D];
	logic signed [CW-1:0] ci_d [1:D];
	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] tq;
	logic signed [TW-1:0] tt;
	logic signed [KW-1:0] k_d [2:D];
	logic [15:0]          f_d [2:D];
	logic [30:0]          m_d [2:D];

	always_comb begin
		tq = (prod_s1 + RND) >>> 12;
		tt = TW'(tq) + TT_OFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_d <= '{default: '0};
		end else if (en) begin
			ctl_d[1] <= in_ctl;
			for (int i = 2; i <= D; i++) ctl_d[i] <= ctl_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_d[1] <= cr_in;
			ci_d[1] <= ci_in;
			for (int i = 2; i <= D; i++) begin
				cr_d[i] <= cr_d[i-1];
				ci_d[i] <= ci_d[i-1];
			end
			prod_s1 <= PW'(wexp) * PW'(lq);
			k_d[2]  <= $signed(tt[TW-1:16]);
			f_d[2]  <= tt[15:0];
			m_d[2]  <= 31'h4000_0000;
		end
	end

	// multiply in the factor for each set fraction bit, most significant first
	for (genvar j = 0; j < gpw_pkg::EXP_STEPS; j++) begin : g_step
		localparam logic [30:0] FAC = 31'(gpw_pkg::exp_factor(j));
		logic [61:0] pr;
		assign pr = m_d[j+2] * FAC;
		always_ff @(posedge clk) begin
			if (en) begin
				m_d[j+3] <= f_d[j+2][15-j] ? pr[60:30] : m_d[j+2];
				f_d[j+3] <= f_d[j+2];
				k_d[j+3] <= k_d[j+2];
			end
		end
	end

	assign out_ctl = ctl_d[D];
	assign cr_out  = cr_d[D];
	assign ci_out  = ci_d[D];
	assign k       = k_d[D];
	assign m       = m_d[D];

endmodule

/* hw/rtl/gpw_scale.sv */
// Output scaling of both cross-spectrum parts by 2^f * 2^k with rounding and
// saturation, seven stages, last one is the output register. Uses gpw_pkg.
module gpw_scale #(
	parameter int SW = gpw_pkg::SAMPLE_WIDTH_DEF,
	localparam int CW = 2 * SW + 1,
	localparam int IPW = $clog2(4 * SW) + 1,
	localparam int KW = IPW + 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  gpw_pkg::ctl_t                     in_ctl,
	input  logic signed [CW-1:0]              cr,
	input  logic signed [CW-1:0]              ci,
	input  logic signed [KW-1:0]              k,
	input  logic [gpw_pkg::MAN_W-1:0]         m,
	output gpw_pkg::ctl_t                     out_ctl,
	output logic [gpw_pkg::OUT_W-1:0]         wr,
	output logic [gpw_pkg::OUT_W-1:0]         wi,
	output logic                              sat
);

	localparam int EXW = $clog2(CW);
	localparam int SSW = KW + 2;

	gpw_pkg::ctl_t        ctl_d [1:7];
	logic signed [CW-1:0] part [2];
	logic                 neg_d [2][1:6];
	logic                 zero_d [2][1:6];
	logic [CW-1:0]        a_d [2][1:2];
	logic signed [KW-1:0] k_d [1:2];
	logic [30:0]          m_d [1:3];
	logic [EXW-1:0]       ex_s2 [2];
	logic [31:0]          a32_s3 [2];
	logic signed [SSW-1:0] s_d [2][3:5];
	logic [62:0]          r_d [2][4:5];
	logic                 big_s5 [2];
	logic                 far_s5 [2];
	logic [31:0]          lsh_s5 [2];
	logic [63:0]          rnd_s5 [2];
	logic [5:0]           nsh_s5 [2];
	logic [31:0]          mag_s6 [2];
	logic                 ovf_s6 [2];
	logic [31:0]          out_s7 [2];
	logic                 sat_s7;
	logic [6:0]           bl [2];
	logic [31:0]          lim5 [2];
	logic [31:0]          lim6 [2];
	logic [5:0]           nsh [2];
	logic [63:0]          mag64 [2];
	logic [31:0]          mag_n [2];
	logic                 ovf_n [2];

	assign part[0] = cr;
	assign part[1] = ci;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			bl[l]   = gpw_pkg::bit_len(64'(a_d[l][1]));
			lim5[l] = neg_d[l][4] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			lim6[l] = neg_d[l][5] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			nsh[l]  = 6'(-s_d[l][4]);
			mag64[l] = far_s5[l] ? 64'd0 : (rnd_s5[l] >> nsh_s5[l]);
			if (!s_d[l][5][SSW-1]) begin
				ovf_n[l] = big_s5[l] || (64'(r_d[l][5]) > 64'(lsh_s5[l]));
				mag_n[l] = ovf_n[l] ? lim6[l] : 32'(r_d[l][5] << s_d[l][5][4:0]);
			end else begin
				ovf_n[l] = mag64[l] > 64'(lim6[l]);
				mag_n[l] = ovf_n[l] ? lim6[l] : mag64[l][31:0];
			end
			if (zero_d[l][5]) begin
				ovf_n[l] = 1'b0;
				mag_n[l] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_d <= '{default: '0};
		end else if (en) begin
			ctl_d[1] <= in_ctl;
			for (int i = 2; i <= 7; i++) ctl_d[i] <= ctl_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_d[1] <= k;
			k_d[2] <= k_d[1];
			m_d[1] <= m;
			m_d[2] <= m_d[1];
			m_d[3] <= m_d[2];
			for (int l = 0; l < 2; l++) begin
				neg_d[l][1]  <= part[l][CW-1];
				zero_d[l][1] <= (part[l] == '0);
				a_d[l][1]    <= part[l][CW-1] ? CW'(-part[l]) : CW'(part[l]);
				for (int i = 2; i <= 6; i++) begin
					neg_d[l][i]  <= neg_d[l][i-1];
					zero_d[l][i] <= zero_d[l][i-1];
				end
				a_d[l][2]  <= a_d[l][1];
				ex_s2[l]   <= (bl[l] > 7'd32) ? EXW'(bl[l] - 7'd32) : '0;
				a32_s3[l]  <= 32'(a_d[l][2] >> ex_s2[l]);
				s_d[l][3]  <= SSW'(k_d[2]) + SSW'({1'b0, ex_s2[l]}) - SSW'(30);
				s_d[l][4]  <= s_d[l][3];
				s_d[l][5]  <= s_d[l][4];
				r_d[l][4]  <= a32_s3[l] * m_d[3];
				r_d[l][5]  <= r_d[l][4];
				big_s5[l]  <= s_d[l][4] >= SSW'(32);
				far_s5[l]  <= s_d[l][4] <= -SSW'(64);
				lsh_s5[l]  <= lim5[l] >> s_d[l][4][4:0];
				nsh_s5[l]  <= nsh[l];
				rnd_s5[l]  <= 64'(r_d[l][4]) + (64'd1 << (nsh[l] - 6'd1));
				mag_s6[l]  <= mag_n[l];
				ovf_s6[l]  <= ovf_n[l];
				out_s7[l]  <= neg_d[l][6] ? 32'(-mag_s6[l]) : mag_s6[l];
			end
			sat_s7 <= ovf_s6[0] | ovf_s6[1];
		end
	end

	assign out_ctl = ctl_d[7];
	assign wr      = out_s7[0];
	assign wi      = out_s7[1];
	assign sat     = sat_s7;

endmodule
